### hdl/gbb_pkg.sv
// Shared constants, payload types and codes for the greyscale 7x7 box blur.
package gbb_pkg;

    // Geometry
    localparam int MAX_WIDTH     = 2048;
    localparam int KERNEL_RADIUS = 3;
    localparam int KDIM          = 2 * KERNEL_RADIUS + 1;
    localparam int STORE_ROWS    = 2 * KERNEL_RADIUS;
    localparam int WIN_COUNT     = KDIM * KDIM;
    localparam int POS_LIMIT     = 2048;

    // Widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 11;
    localparam int SIZE_W   = 12;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = $clog2(STORE_ROWS);
    localparam int COLSUM_W = $clog2(KDIM * 255 + 1);
    localparam int SUM_W    = $clog2(WIN_COUNT * 255 + 1);

    // Size limits after saturation
    localparam int SIZE_MIN   = KDIM;
    localparam int WIDTH_MAX  = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
    localparam int HEIGHT_MAX = POS_LIMIT;

    // Grey weights, unsigned Q0.16
    localparam int GREY_W     = 24;
    localparam int GREY_SHIFT = 16;
    localparam logic [GREY_W-1:0] WEIGHT_FIRST  = GREY_W'(13763);
    localparam logic [GREY_W-1:0] WEIGHT_SECOND = GREY_W'(46531);
    localparam logic [GREY_W-1:0] WEIGHT_THIRD  = GREY_W'(4588);

    // Reciprocal of the window count for the mean
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + WIN_COUNT - 1) / WIN_COUNT;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1280);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(720);

    typedef struct packed {
        logic [PIX_W-1:0] chan_first;
        logic [PIX_W-1:0] chan_second;
        logic [PIX_W-1:0] chan_third;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] blurred_value;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_done;
    } pixel_out_t;

endpackage

### hdl/gbb_grey_conv.sv
// Weighted three-channel to grey conversion, truncated to 8 bits.
module gbb_grey_conv (
    input  logic [gbb_pkg::PIX_W-1:0] chan_first,
    input  logic [gbb_pkg::PIX_W-1:0] chan_second,
    input  logic [gbb_pkg::PIX_W-1:0] chan_third,
    output logic [gbb_pkg::PIX_W-1:0] grey
);

    logic [gbb_pkg::GREY_W-1:0] acc;

    // Weighted sum fits 24 bits; keep the integer part
    assign acc = gbb_pkg::WEIGHT_FIRST  * gbb_pkg::GREY_W'(chan_first)
               + gbb_pkg::WEIGHT_SECOND * gbb_pkg::GREY_W'(chan_second)
               + gbb_pkg::WEIGHT_THIRD  * gbb_pkg::GREY_W'(chan_third);

    assign grey = acc[gbb_pkg::GREY_SHIFT +: gbb_pkg::PIX_W];

endmodule

### hdl/gbb_line_store.sv
// Line store: one grey row per bank, all banks read at one column per beat.
module gbb_line_store (
    input  logic                              clk,
    input  logic                              acc_en,
    input  logic [gbb_pkg::SLOT_W-1:0]        wr_slot,
    input  logic [gbb_pkg::ADDR_W-1:0]        addr,
    input  logic [gbb_pkg::PIX_W-1:0]         wr_data,
    output logic [gbb_pkg::PIX_W-1:0]         rd_data [gbb_pkg::STORE_ROWS]
);

    for (genvar b = 0; b < gbb_pkg::STORE_ROWS; b++)
    begin : g_bank
        logic [gbb_pkg::PIX_W-1:0] mem [gbb_pkg::MAX_WIDTH];
        logic [gbb_pkg::PIX_W-1:0] rd_reg;

        // Read returns the old entry; the current row's bank takes the new pixel
        always_ff @(posedge clk)
        begin
            if (acc_en)
            begin
                if (wr_slot == gbb_pkg::SLOT_W'(b))
                begin
                    mem[addr] <= wr_data;
                end
                rd_reg <= mem[addr];
            end
        end

        assign rd_data[b] = rd_reg;
    end

endmodule

### hdl/gbb_window_sum.sv
// Window of column sums: shifts in one column per pixel, gives the window total.
module gbb_window_sum (
    input  logic                         clk,
    input  logic                         shift_en,
    input  logic [gbb_pkg::PIX_W-1:0]    grey_in,
    input  logic [gbb_pkg::PIX_W-1:0]    line_in [gbb_pkg::STORE_ROWS],
    output logic [gbb_pkg::SUM_W-1:0]    total
);

    logic [gbb_pkg::COLSUM_W-1:0] colsum_reg [gbb_pkg::KDIM];
    logic [gbb_pkg::COLSUM_W-1:0] colsum_next;

    // Vertical sum of the new column
    always_comb
    begin
        colsum_next = gbb_pkg::COLSUM_W'(grey_in);
        for (int k = 0; k < gbb_pkg::STORE_ROWS; k++)
        begin
            colsum_next = colsum_next + gbb_pkg::COLSUM_W'(line_in[k]);
        end
    end

    // Oldest column drops out at index 0
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int c = 0; c < gbb_pkg::KDIM - 1; c++)
            begin
                colsum_reg[c] <= colsum_reg[c + 1];
            end
            colsum_reg[gbb_pkg::KDIM - 1] <= colsum_next;
        end
    end

    // Horizontal sum over the held columns
    always_comb
    begin
        total = '0;
        for (int c = 0; c < gbb_pkg::KDIM; c++)
        begin
            total = total + gbb_pkg::SUM_W'(colsum_reg[c]);
        end
    end

endmodule

### hdl/greyscale_box_blur_7x7_unit.sv
// Top level: greyscale conversion and 7x7 box blur on a raster pixel stream.
// Throughput: one pixel per cycle unless out_ready stalls the pipeline, set by the
// line store banks, which read and write one column per beat, and the four-register
// pipeline behind them. A result passes stages 1, 2, 3 and the output register.
// Reset: position counters to zero, frame size to 1280x720, pipeline empty;
// the line store is not cleared and is valid only once written.
module greyscale_box_blur_7x7_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  gbb_pkg::pixel_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output gbb_pkg::pixel_out_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbb_pkg::SIZE_W-1:0]       cfg_data
);

    typedef struct packed {
        logic                       emit;
        logic                       done;
        logic [gbb_pkg::POS_W-1:0]  row;
        logic [gbb_pkg::POS_W-1:0]  col;
    } pos_meta_t;

    function automatic logic [gbb_pkg::SIZE_W-1:0] clamp_size(
        input logic [gbb_pkg::SIZE_W-1:0] v,
        input logic [gbb_pkg::SIZE_W-1:0] hi
    );
        logic [gbb_pkg::SIZE_W-1:0] r;
        if (v < gbb_pkg::SIZE_W'(gbb_pkg::SIZE_MIN))
            r = gbb_pkg::SIZE_W'(gbb_pkg::SIZE_MIN);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    // Effective frame size
    logic [gbb_pkg::SIZE_W-1:0] w_eff_reg;
    logic [gbb_pkg::SIZE_W-1:0] h_eff_reg;

    // Position counters
    logic [gbb_pkg::POS_W-1:0]  row_count_reg, row_count_next;
    logic [gbb_pkg::POS_W-1:0]  col_count_reg, col_count_next;
    logic [gbb_pkg::SLOT_W-1:0] row_slot_reg, row_slot_next;

    // Current pixel position
    logic [gbb_pkg::POS_W-1:0]  cur_row, cur_col;
    logic [gbb_pkg::SLOT_W-1:0] cur_slot;
    logic [gbb_pkg::SIZE_W-1:0] row_ext, col_ext, row_inc, col_inc;
    pos_meta_t                  cur_meta;

    // Pipeline
    logic                         accept;
    logic [gbb_pkg::PIX_W-1:0]    grey;
    logic [gbb_pkg::PIX_W-1:0]    line_rd [gbb_pkg::STORE_ROWS];
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                         out_valid_reg;
    logic                         s1_free, s2_free, s3_free, out_free;
    logic                         s1_move;
    logic [gbb_pkg::PIX_W-1:0]    s1_grey_reg;
    pos_meta_t                    s1_meta_reg, s2_meta_reg, s3_meta_reg;
    logic [gbb_pkg::SUM_W-1:0]    win_total;
    logic [gbb_pkg::SUM_W-1:0]    s3_total_reg;
    logic [gbb_pkg::PROD_W-1:0]   mean_prod;
    gbb_pkg::pixel_out_t          out_data_reg;

    // Configuration writes, saturated on the way in
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= gbb_pkg::WIDTH_RESET;
            h_eff_reg <= gbb_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gbb_pkg::CFG_FRAME_WIDTH:
                    w_eff_reg <= clamp_size(cfg_data, gbb_pkg::SIZE_W'(gbb_pkg::WIDTH_MAX));
                gbb_pkg::CFG_FRAME_HEIGHT:
                    h_eff_reg <= clamp_size(cfg_data, gbb_pkg::SIZE_W'(gbb_pkg::HEIGHT_MAX));
                default:
                    ;
            endcase
        end
    end

    // Ready chain: each stage frees when empty or moving on
    assign out_free = !out_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && in_ready;

    // Position of the incoming pixel
    always_comb
    begin
        cur_row  = in_data.frame_start ? '0 : row_count_reg;
        cur_col  = in_data.frame_start ? '0 : col_count_reg;
        cur_slot = in_data.frame_start ? '0 : row_slot_reg;
        row_ext  = gbb_pkg::SIZE_W'(cur_row);
        col_ext  = gbb_pkg::SIZE_W'(cur_col);
        row_inc  = row_ext + 1'b1;
        col_inc  = col_ext + 1'b1;

        cur_meta.emit = (row_ext >= gbb_pkg::SIZE_W'(gbb_pkg::STORE_ROWS))
                     && (col_ext >= gbb_pkg::SIZE_W'(gbb_pkg::STORE_ROWS))
                     && (row_ext < h_eff_reg) && (col_ext < w_eff_reg);
        cur_meta.done = (row_inc == h_eff_reg) && (col_inc == w_eff_reg);
        cur_meta.row  = cur_row - gbb_pkg::POS_W'(gbb_pkg::KERNEL_RADIUS);
        cur_meta.col  = cur_col - gbb_pkg::POS_W'(gbb_pkg::KERNEL_RADIUS);

        // Advance with wrap at the effective width and height
        row_count_next = cur_row;
        row_slot_next  = cur_slot;
        col_count_next = col_inc[gbb_pkg::POS_W-1:0];
        if (col_inc >= w_eff_reg)
        begin
            col_count_next = '0;
            if (row_inc >= h_eff_reg)
            begin
                row_count_next = '0;
                row_slot_next  = '0;
            end
            else
            begin
                row_count_next = row_inc[gbb_pkg::POS_W-1:0];
                row_slot_next  = (cur_slot == gbb_pkg::SLOT_W'(gbb_pkg::STORE_ROWS - 1))
                               ? '0 : cur_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            row_slot_reg  <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            row_slot_reg  <= row_slot_next;
        end
    end

    gbb_grey_conv u_grey (
        .chan_first  (in_data.chan_first),
        .chan_second (in_data.chan_second),
        .chan_third  (in_data.chan_third),
        .grey        (grey)
    );

    gbb_line_store u_lines (
        .clk     (clk),
        .acc_en  (accept),
        .wr_slot (cur_slot),
        .addr    (cur_col[gbb_pkg::ADDR_W-1:0]),
        .wr_data (grey),
        .rd_data (line_rd)
    );

    gbb_window_sum u_window (
        .clk      (clk),
        .shift_en (s1_move),
        .grey_in  (s1_grey_reg),
        .line_in  (line_rd),
        .total    (win_total)
    );

    // Pipeline valids; stage 2 onwards carries only result beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= accept;
            if (s2_free)
                s2_valid_reg <= s1_move && s1_meta_reg.emit;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload
    assign mean_prod = gbb_pkg::PROD_W'(s3_total_reg)
                     * gbb_pkg::PROD_W'(gbb_pkg::RECIP_MULT);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_grey_reg <= grey;
            s1_meta_reg <= cur_meta;
        end
        if (s1_move)
            s2_meta_reg <= s1_meta_reg;
        if (s2_valid_reg && s3_free)
        begin
            s3_meta_reg  <= s2_meta_reg;
            s3_total_reg <= win_total;
        end
        if (s3_valid_reg && out_free)
        begin
            out_data_reg.blurred_value <= mean_prod[gbb_pkg::RECIP_SHIFT +: gbb_pkg::PIX_W];
            out_data_reg.out_row       <= s3_meta_reg.row;
            out_data_reg.out_col       <= s3_meta_reg.col;
            out_data_reg.frame_done    <= s3_meta_reg.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // Row slot always names one of the line store banks
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_slot_reg < gbb_pkg::SLOT_W'(gbb_pkg::STORE_ROWS))
        else $error("row slot out of range");

    // Input stalls only when every stage holds a beat and the output is blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                       && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    // Frame end result sits on the last interior row
    a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_done) |->
        (gbb_pkg::SIZE_W'(out_data.out_row)
         == h_eff_reg - gbb_pkg::SIZE_W'(gbb_pkg::KERNEL_RADIUS + 1)))
        else $error("frame done flagged off the last interior row");

    // A result beat only comes from a beat that was in the stage before
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s3_valid_reg))
        else $error("result without a source beat");
`endif

endmodule
